>>> hdl/tsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsq_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 6;

  // Operation codes on the command channel.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } tsq_status_t;

  typedef struct packed {
    tsq_status_t        status;
    logic [WORD_W-1:0]  removed;
    logic [WORD_W-1:0]  front;
    logic [WORD_W-1:0]  back;
    logic [COUNT_W-1:0] count;
  } tsq_res_t;

endpackage

`default_nettype wire

>>> hdl/two_stack_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// -------   --------------------   ----------------------------------------------
// cmd       cmd_valid / cmd_ready  op, value
// rsp       rsp_valid / rsp_ready  status, removed_value, front_value, back_value,
//                                  item_count
//
// An enqueue, an underflow or a dequeue that leaves the output stack empty goes
// from command accept straight to the response state; a dequeue that must fetch
// the next output-stack top passes through a read state first. A dequeue that
// finds the output stack empty first moves all n intake words, one per cycle
// through the intake memory's read port, and then pops like any other dequeue.
// Reset clears the state machine and both stack depths; memory contents stay as
// they are and are never read before being written.
// A new command is taken while the previous response waits in the output
// register; the next response holds in the controller until that register frees.

module two_stack_queue #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire logic               op,
  input  wire logic signed [31:0] value,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output logic             [1:0]  status,
  output logic signed      [31:0] removed_value,
  output logic signed      [31:0] front_value,
  output logic signed      [31:0] back_value,
  output logic             [5:0]  item_count
);
  import tsq_pkg::*;

  logic     res_valid;
  logic     res_take;
  tsq_res_t res;

  // Controller: both stack memories, depths and the refill sequencer.
  tsq_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .op        (op),
    .value     (value),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Load the output register when it is empty or being drained this cycle.
  assign res_take = res_valid && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Payload: hold until the next response is loaded.
  always_ff @(posedge clk) begin
    if (res_take) begin
      status        <= res.status;
      removed_value <= res.removed;
      front_value   <= res.front;
      back_value    <= res.back;
      item_count    <= res.count;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tsq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tsq_ctrl #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cmd_valid,
  output logic                          cmd_ready,
  input  wire logic                     op,
  input  wire logic [31:0]              value,
  output logic                          res_valid,
  input  wire logic                     res_take,
  output tsq_pkg::tsq_res_t             res
);
  import tsq_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MOVE = 6'b000010,
    S_POP  = 6'b000100,
    S_READ = 6'b001000,
    S_EMIT = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t state;

  logic [CW-1:0]     in_depth;
  logic [CW-1:0]     out_depth;
  logic [CW-1:0]     mv_n;
  logic [CW-1:0]     rd_cnt;
  logic [CW-1:0]     wr_cnt;
  logic [WORD_W-1:0] in_top;
  logic [WORD_W-1:0] in_bot;
  logic [WORD_W-1:0] out_top;
  logic [WORD_W-1:0] out_bot;
  tsq_status_t       status_q;
  logic [WORD_W-1:0] removed_q;

  logic [WORD_W-1:0] intake_mem [STACK_DEPTH];
  logic [WORD_W-1:0] output_mem [STACK_DEPTH];
  logic [WORD_W-1:0] intake_rdata;
  logic [WORD_W-1:0] output_rdata;

  logic          accept;
  logic          do_pop;
  logic          in_full;
  logic          in_we;
  logic [AW-1:0] in_waddr;
  logic          in_re;
  logic [AW-1:0] in_raddr;
  logic          out_we;
  logic [AW-1:0] out_waddr;
  logic          out_re;
  logic [AW-1:0] out_raddr;
  logic [CW:0]   count_sum;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign in_full   = (in_depth == CW'(STACK_DEPTH));
  assign do_pop    = (accept && op == OP_DEQ && out_depth != '0) || (state == S_POP);

  always_comb begin
    in_we     = 1'b0;
    in_waddr  = in_depth[AW-1:0];
    in_re     = 1'b0;
    in_raddr  = AW'(in_depth - 1'b1);
    out_we    = 1'b0;
    out_waddr = wr_cnt[AW-1:0];
    out_re    = 1'b0;
    out_raddr = AW'(out_depth - CW'(2));
    if (accept && op == OP_ENQ && !in_full) begin
      in_we = 1'b1;
    end
    if (accept && op == OP_DEQ && out_depth == '0 && in_depth != '0) begin
      in_re = 1'b1;
    end
    if (do_pop && out_depth >= CW'(2)) begin
      out_re = 1'b1;
    end
    if (state == S_MOVE) begin
      out_we = 1'b1;
      if (rd_cnt != mv_n) begin
        in_re    = 1'b1;
        in_raddr = AW'(mv_n - rd_cnt - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_we) begin
      intake_mem[in_waddr] <= value;
    end
    if (in_re) begin
      intake_rdata <= intake_mem[in_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      output_mem[out_waddr] <= intake_rdata;
    end
    if (out_re) begin
      output_rdata <= output_mem[out_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_depth  <= '0;
      out_depth <= '0;
      mv_n      <= '0;
      rd_cnt    <= '0;
      wr_cnt    <= '0;
    end else begin
      if (do_pop) begin
        removed_q <= out_top;
        status_q  <= ST_OK;
        out_depth <= out_depth - 1'b1;
        state     <= (out_depth >= CW'(2)) ? S_READ : S_EMIT;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_ENQ) begin
              removed_q <= '0;
              state     <= S_EMIT;
              if (in_full) begin
                status_q <= ST_OVERFLOW;
              end else begin
                status_q <= ST_OK;
                in_depth <= in_depth + 1'b1;
                in_top   <= value;
                if (in_depth == '0) begin
                  in_bot <= value;
                end
              end
            end else if (out_depth == '0) begin
              if (in_depth == '0) begin
                status_q  <= ST_UNDERFLOW;
                removed_q <= '0;
                state     <= S_EMIT;
              end else begin
                mv_n   <= in_depth;
                rd_cnt <= CW'(1);
                wr_cnt <= '0;
                state  <= S_MOVE;
              end
            end
          end
        end
        S_MOVE: begin
          wr_cnt <= wr_cnt + 1'b1;
          if (rd_cnt != mv_n) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (wr_cnt == mv_n - 1'b1) begin
            out_depth <= mv_n;
            in_depth  <= '0;
            out_top   <= in_bot;
            out_bot   <= in_top;
            state     <= S_POP;
          end
        end
        S_POP: begin
          // pop handled above
        end
        S_READ: begin
          out_top <= output_rdata;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign count_sum  = {1'b0, in_depth} + {1'b0, out_depth};
  assign res_valid  = (state == S_EMIT);

  always_comb begin
    res.status  = status_q;
    res.removed = removed_q;
    res.count   = COUNT_W'(count_sum);
    if (out_depth != '0) begin
      res.front = out_top;
    end else if (in_depth != '0) begin
      res.front = in_bot;
    end else begin
      res.front = '0;
    end
    if (in_depth != '0) begin
      res.back = in_top;
    end else if (out_depth != '0) begin
      res.back = out_bot;
    end else begin
      res.back = '0;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (in_depth <= CW'(STACK_DEPTH)) && (out_depth <= CW'(STACK_DEPTH)))
    else $error("stack depth beyond capacity");

  a_move_setup: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> (in_depth == mv_n && out_depth == '0 && wr_cnt < mv_n))
    else $error("refill running with inconsistent depths");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (out_depth != '0 && in_depth == '0))
    else $error("pop after refill with empty output stack");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_UNDERFLOW) |-> (count_sum == '0))
    else $error("underflow reported on non-empty queue");

endmodule

`default_nettype wire
